[hw/rtl/wprs_pkg.sv]
// Shared types and constants for the white pixel region steering block.
// Used by every module under hw/rtl; depends on nothing else.
package wprs_pkg;

    // Frame size limits and derived position widths.
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int SIZE_W     = 12;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int POS3_W     = SIZE_W + 1;

    localparam logic [SIZE_W-1:0] MAX_WIDTH_V  = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] MAX_HEIGHT_V = SIZE_W'(MAX_HEIGHT);

    localparam int CHAN_W = 8;

    // Tallies and result encoding.
    localparam int TALLY_W = 23;
    localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

    localparam logic [1:0] DIR_STOP     = 2'd0;
    localparam logic [1:0] DIR_STRAIGHT = 2'd1;
    localparam logic [1:0] DIR_RIGHT    = 2'd2;
    localparam logic [1:0] DIR_LEFT     = 2'd3;

    localparam logic [6:0]        SPEED_MOVE = 7'd102;
    localparam logic signed [8:0] TURN_LEFT  = 9'sd128;
    localparam logic signed [8:0] TURN_RIGHT = -9'sd128;

    localparam logic [1:0] REGION_LEFT   = 2'd0;
    localparam logic [1:0] REGION_MIDDLE = 2'd1;
    localparam logic [1:0] REGION_RIGHT  = 2'd2;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_WHITE_LEVEL  = 2'd2;

    // Queue between the classifier and the tally engine.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic       white;
        logic [1:0] region;
        logic       eof;
    } wprs_item_t;

    typedef struct packed {
        logic [TALLY_W-1:0] right_count;
        logic [TALLY_W-1:0] middle_count;
        logic [TALLY_W-1:0] left_count;
        logic signed [8:0]  turn_rate;
        logic [6:0]         linear_speed;
        logic [1:0]         direction;
    } wprs_result_t;

    localparam int RESULT_W = $bits(wprs_result_t);
    localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

endpackage

[hw/rtl/wprs_front.sv]
// Front end: accepts pixels, tracks the frame position and classifies each pixel
// into white flag, region and end-of-frame mark. Depends on wprs_pkg.
module wprs_front import wprs_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [3*CHAN_W-1:0] s_tdata,
    input  logic [SIZE_W-1:0]   frame_width,
    input  logic [SIZE_W-1:0]   frame_height,
    input  logic [CHAN_W-1:0]   white_level,
    input  logic                push_ready,
    output logic                push_valid,
    output wprs_item_t          push_item
);

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [SIZE_W-1:0] w_eff, h_eff;
    logic [POS3_W-1:0] col3, w1, w2;
    logic [SIZE_W-1:0] col_inc, row_inc;
    logic              row_end, frame_end, accept;
    logic [CHAN_W-1:0] red, green, blue;

    assign red   = s_tdata[CHAN_W-1:0];
    assign green = s_tdata[2*CHAN_W-1:CHAN_W];
    assign blue  = s_tdata[3*CHAN_W-1:2*CHAN_W];

    // A zero size acts as one; oversize values clamp to the maximum.
    always_comb begin
        if (frame_width == '0) begin
            w_eff = SIZE_W'(1);
        end else if (frame_width > MAX_WIDTH_V) begin
            w_eff = MAX_WIDTH_V;
        end else begin
            w_eff = frame_width;
        end
        if (frame_height == '0) begin
            h_eff = SIZE_W'(1);
        end else if (frame_height > MAX_HEIGHT_V) begin
            h_eff = MAX_HEIGHT_V;
        end else begin
            h_eff = frame_height;
        end
    end

    assign col3 = (POS3_W'(col_reg) << 1) + POS3_W'(col_reg);
    assign w1   = POS3_W'(w_eff);
    assign w2   = POS3_W'(w_eff) << 1;

    assign col_inc   = SIZE_W'(col_reg) + SIZE_W'(1);
    assign row_inc   = SIZE_W'(row_reg) + SIZE_W'(1);
    assign row_end   = !(col_inc < w_eff);
    assign frame_end = row_end && !(row_inc < h_eff);

    assign accept     = s_tvalid && push_ready;
    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;

    always_comb begin
        push_item.white = (red == white_level) && (green == white_level)
                          && (blue == white_level);
        if (col3 <= w1) begin
            push_item.region = REGION_LEFT;
        end else if (col3 <= w2) begin
            push_item.region = REGION_MIDDLE;
        end else begin
            push_item.region = REGION_RIGHT;
        end
        push_item.eof = frame_end;
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (row_end) begin
                col_next = '0;
                row_next = frame_end ? '0 : row_inc[ROW_W-1:0];
            end else begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

[hw/rtl/wprs_queue.sv]
// Short queue of classified pixels between front end and tally engine.
// Depends on wprs_pkg.
module wprs_queue import wprs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push_valid,
    output logic       push_ready,
    input  wprs_item_t push_item,
    output logic       pop_valid,
    input  logic       pop_ready,
    output wprs_item_t pop_item
);

    wprs_item_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;
    logic                push, pop;

    assign push_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hw/rtl/wprs_back.sv]
// Back end: keeps the three region tallies, makes the steering decision at
// end of frame and holds the result in an output register. Depends on wprs_pkg.
module wprs_back import wprs_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         pop_valid,
    output logic         pop_ready,
    input  wprs_item_t   pop_item,
    output logic         m_tvalid,
    input  logic         m_tready,
    output wprs_result_t m_result
);

    logic [TALLY_W-1:0] left_reg, left_next;
    logic [TALLY_W-1:0] middle_reg, middle_next;
    logic [TALLY_W-1:0] right_reg, right_next;
    logic [TALLY_W-1:0] left_upd, middle_upd, right_upd;
    logic               m_valid_reg, m_valid_next;
    wprs_result_t       result_reg, result_next;
    logic               pop;

    // Only an end-of-frame item needs room in the output register.
    assign pop_ready = !pop_item.eof || !m_valid_reg || m_tready;
    assign pop       = pop_valid && pop_ready;

    function automatic logic [TALLY_W-1:0] bump(input logic [TALLY_W-1:0] t);
        return (t != TALLY_MAX) ? t + TALLY_W'(1) : t;
    endfunction

    always_comb begin
        left_upd   = left_reg;
        middle_upd = middle_reg;
        right_upd  = right_reg;
        if (pop_item.white) begin
            case (pop_item.region)
                REGION_LEFT:   left_upd   = bump(left_reg);
                REGION_MIDDLE: middle_upd = bump(middle_reg);
                default:       right_upd  = bump(right_reg);
            endcase
        end
    end

    always_comb begin
        result_next.left_count   = left_upd;
        result_next.middle_count = middle_upd;
        result_next.right_count  = right_upd;
        if (left_upd == '0 && middle_upd == '0 && right_upd == '0) begin
            result_next.direction    = DIR_STOP;
            result_next.linear_speed = '0;
            result_next.turn_rate    = '0;
        end else if (left_upd >= middle_upd && left_upd >= right_upd) begin
            result_next.direction    = DIR_LEFT;
            result_next.linear_speed = SPEED_MOVE;
            result_next.turn_rate    = TURN_LEFT;
        end else if (middle_upd >= right_upd) begin
            result_next.direction    = DIR_STRAIGHT;
            result_next.linear_speed = SPEED_MOVE;
            result_next.turn_rate    = '0;
        end else begin
            result_next.direction    = DIR_RIGHT;
            result_next.linear_speed = SPEED_MOVE;
            result_next.turn_rate    = TURN_RIGHT;
        end
    end

    always_comb begin
        left_next    = left_reg;
        middle_next  = middle_reg;
        right_next   = right_reg;
        m_valid_next = m_valid_reg && !m_tready;
        if (pop) begin
            if (pop_item.eof) begin
                left_next    = '0;
                middle_next  = '0;
                right_next   = '0;
                m_valid_next = 1'b1;
            end else begin
                left_next   = left_upd;
                middle_next = middle_upd;
                right_next  = right_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && pop_item.eof) begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg    <= '0;
            middle_reg  <= '0;
            right_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            left_reg    <= left_next;
            middle_reg  <= middle_next;
            right_reg   <= right_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_result = result_reg;

endmodule

[hw/rtl/white_pixel_region_steering.sv]
// Result path: a frame's last pixel is written into the queue, then its tally pop loads the
// output register and raises m_tvalid, without waiting for a backlog when the queue is empty.
// Throughput: one pixel per cycle; a waiting result only stops the tally engine when the
// next frame's last pixel reaches it, and then the 4-entry queue fills before s_tready drops.
// Reset: synchronous, active low; clears position, tallies, queue and output valid,
// and loads frame_width 800, frame_height 800 and white_level 255.
module white_pixel_region_steering import wprs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // red [7:0], green [15:8], blue [23:16]
    input  logic [3*CHAN_W-1:0]   s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // direction [1:0], linear_speed [8:2], turn_rate [17:9], left_count [40:18],
    // middle_count [63:41], right_count [86:64], zero [87]
    output logic [TDATA_W-1:0]    m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [SIZE_W-1:0]     cfg_wdata
);

    logic [SIZE_W-1:0] width_reg, height_reg;
    logic [CHAN_W-1:0] white_reg;

    logic         push_valid, push_ready, pop_valid, pop_ready;
    wprs_item_t   push_item, pop_item;
    wprs_result_t result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= SIZE_W'(800);
            height_reg <= SIZE_W'(800);
            white_reg  <= CHAN_W'(255);
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                REG_FRAME_WIDTH:  width_reg  <= cfg_wdata;
                REG_FRAME_HEIGHT: height_reg <= cfg_wdata;
                REG_WHITE_LEVEL:  white_reg  <= cfg_wdata[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    wprs_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .white_level  (white_reg),
        .push_ready   (push_ready),
        .push_valid   (push_valid),
        .push_item    (push_item)
    );

    wprs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    wprs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_result  (result)
    );

    assign m_tdata = TDATA_W'(result);

    // A stop request carries no motion and empty counts.
    a_stop_is_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && result.direction == DIR_STOP |->
            result.linear_speed == '0 && result.turn_rate == '0 &&
            result.left_count == '0 && result.middle_count == '0 &&
            result.right_count == '0)
        else $error("stop request with nonzero motion or counts");

    // A left turn means the left tally is at least as large as each other tally.
    a_left_is_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && result.direction == DIR_LEFT |->
            result.left_count >= result.middle_count &&
            result.left_count >= result.right_count &&
            result.linear_speed == SPEED_MOVE)
        else $error("left turn without left region winning");

    // The front end only stalls when the queue holds items for the back end.
    a_stall_has_backlog: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> pop_valid)
        else $error("input stalled while queue is empty");

endmodule
